/* rtl/assert_macros.svh */
// assertion wrappers for the range sum segment tree rtl
// no dependencies; included by rsst_datapath, the module that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check at every clock edge outside reset
`define RSST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every clock edge, reset included
`define RSST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSST_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/rsst_pkg.sv */
// shared constants, opcodes and controller/datapath interface types
// no dependencies
`default_nettype none

package rsst_pkg;

	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int DATA_W = 32;
	localparam int MAX_ELEMENTS_DEF = 1024;

	typedef enum logic {
		OP_SET = 1'b0,
		OP_QUERY = 1'b1
	} rsst_op_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic descend;
		logic leaf_wr;
		logic up_rd;
		logic up_wr;
		logic q_visit;
		logic out_load;
	} rsst_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_query;
		logic in_skip;
		logic is_leaf;
		logic is_root;
		logic q_partial;
		logic stk_empty;
		logic out_free;
	} rsst_status_t;

	// width of element positions and of the last-index register
	function automatic int pos_width(input int max_elems);
		return ($clog2(max_elems) > IDX_W) ? $clog2(max_elems) : IDX_W;
	endfunction

endpackage

`default_nettype wire

/* rtl/rsst_node_ram.sv */
// node sum memory: one write port, two registered read ports
// depends on rsst_pkg
`default_nettype none

module rsst_node_ram
	import rsst_pkg::*;
#(
	parameter int AW = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr0,
	input  logic [AW-1:0]     raddr1,
	output logic [DATA_W-1:0] rdata0,
	output logic [DATA_W-1:0] rdata1
);

	localparam int DEPTH = 1 << AW;

	logic [DATA_W-1:0] node_sums_q [DEPTH];
	logic [DATA_W-1:0] rdata0_q;
	logic [DATA_W-1:0] rdata1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			node_sums_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0_q <= node_sums_q[raddr0];
		rdata1_q <= node_sums_q[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

`default_nettype wire

/* rtl/rsst_ctrl.sv */
// sequencing state machine: clear pass, set walk, query traversal
// depends on rsst_pkg
`default_nettype none

module rsst_ctrl
	import rsst_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  rsst_status_t status,
	output rsst_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DESC,
		S_UP_RD,
		S_UP_WR,
		S_Q_VISIT,
		S_Q_DRAIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.is_query) begin
						state_d = status.in_skip ? S_Q_DRAIN : S_Q_VISIT;
					end else if (!status.in_skip) begin
						state_d = S_DESC;
					end
				end
			end
			S_DESC: begin
				if (status.is_leaf) begin
					cmd.leaf_wr = 1'b1;
					state_d = status.is_root ? S_IDLE : S_UP_RD;
				end else begin
					cmd.descend = 1'b1;
				end
			end
			S_UP_RD: begin
				cmd.up_rd = 1'b1;
				state_d = S_UP_WR;
			end
			S_UP_WR: begin
				cmd.up_wr = 1'b1;
				state_d = status.is_root ? S_IDLE : S_UP_RD;
			end
			S_Q_VISIT: begin
				cmd.q_visit = 1'b1;
				if (!status.q_partial && status.stk_empty) begin
					state_d = S_Q_DRAIN;
				end
			end
			S_Q_DRAIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* rtl/rsst_datapath.sv */
// tree walk registers, query stack, accumulator and result register
// depends on rsst_pkg, rsst_node_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rsst_datapath
	import rsst_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	localparam int POS_W = pos_width(MAX_ELEMENTS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rsst_cmd_t                cmd,
	output rsst_status_t             status,
	input  logic [POS_W-1:0]         last,
	input  logic                     opcode,
	input  logic [IDX_W-1:0]         low_index,
	input  logic [IDX_W-1:0]         high_index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] range_sum
);

	localparam int AW = $clog2(4 * MAX_ELEMENTS);
	localparam int STK_D = $clog2(MAX_ELEMENTS) + 1;
	localparam int STK_IW = $clog2(STK_D);
	localparam int SP_W = $clog2(STK_D + 1);

	logic [AW-1:0]     cur_k_q;
	logic [POS_W-1:0]  cur_b_q;
	logic [POS_W-1:0]  cur_e_q;
	logic [POS_W-1:0]  lo_q;
	logic [POS_W-1:0]  hi_q;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] acc_q;
	logic              pend_q;
	logic [SP_W-1:0]   sp_q;
	logic [AW-1:0]     stk_k_q [STK_D];
	logic [POS_W-1:0]  stk_b_q [STK_D];
	logic [POS_W-1:0]  stk_e_q [STK_D];
	logic [AW-1:0]     clr_addr_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] range_sum_q;

	logic [POS_W-1:0]  lo_ext;
	logic [POS_W-1:0]  hi_ext;
	logic [POS_W-1:0]  hi_clip;
	logic              in_is_query;
	logic              in_skip;
	logic [POS_W:0]    mid_sum;
	logic [POS_W-1:0]  mid;
	logic [POS_W-1:0]  mid_p1;
	logic [AW-1:0]     k_left;
	logic [AW-1:0]     k_right;
	logic [AW-1:0]     pair0;
	logic [AW-1:0]     pair1;
	logic              q_disjoint;
	logic              q_contained;
	logic              q_partial;
	logic              stk_empty;
	logic [SP_W-1:0]   sp_dec;
	logic [DATA_W-1:0] acc_next;
	logic [DATA_W-1:0] up_sum;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr0;
	logic [DATA_W-1:0] ram_rdata0;
	logic [DATA_W-1:0] ram_rdata1;

	// request decode
	assign lo_ext = POS_W'(low_index);
	assign hi_ext = POS_W'(high_index);
	assign hi_clip = (hi_ext > last) ? last : hi_ext;
	assign in_is_query = (rsst_op_t'(opcode) == OP_QUERY);
	assign in_skip = in_is_query ? ((lo_ext > hi_ext) || (lo_ext > last)) : (lo_ext > last);

	// node split
	assign mid_sum = {1'b0, cur_b_q} + {1'b0, cur_e_q};
	assign mid = mid_sum[POS_W:1];
	assign mid_p1 = mid + POS_W'(1);
	assign k_left = {cur_k_q[AW-2:0], 1'b0};
	assign k_right = {cur_k_q[AW-2:0], 1'b1};
	assign pair0 = {cur_k_q[AW-1:1], 1'b0};
	assign pair1 = {cur_k_q[AW-1:1], 1'b1};

	// query node class
	assign q_disjoint = (lo_q > cur_e_q) || (hi_q < cur_b_q);
	assign q_contained = (cur_b_q >= lo_q) && (cur_e_q <= hi_q);
	assign q_partial = !q_disjoint && !q_contained;
	assign stk_empty = (sp_q == '0);
	assign sp_dec = sp_q - SP_W'(1);

	assign acc_next = acc_q + (pend_q ? ram_rdata0 : '0);
	assign up_sum = ram_rdata0 + ram_rdata1;

	// memory ports
	assign ram_we = cmd.clr || cmd.leaf_wr || cmd.up_wr;
	assign ram_waddr = cmd.clr ? clr_addr_q : cur_k_q;
	assign ram_wdata = cmd.clr ? '0 : (cmd.leaf_wr ? value_q : up_sum);
	assign ram_raddr0 = cmd.up_rd ? pair0 : cur_k_q;

	rsst_node_ram #(
		.AW(AW)
	) u_node_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr0(ram_raddr0),
		.raddr1(pair1),
		.rdata0(ram_rdata0),
		.rdata1(ram_rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			sp_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			pend_q <= cmd.q_visit && q_contained;
			if (cmd.load) begin
				sp_q <= '0;
			end else if (cmd.q_visit) begin
				if (q_partial) begin
					sp_q <= sp_q + SP_W'(1);
				end else if (!stk_empty) begin
					sp_q <= sp_dec;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= cmd.load ? '0 : acc_next;
		if (cmd.load) begin
			lo_q <= lo_ext;
			hi_q <= hi_clip;
			value_q <= value;
			cur_k_q <= AW'(1);
			cur_b_q <= '0;
			cur_e_q <= last;
		end else if (cmd.descend) begin
			if (lo_q <= mid) begin
				cur_k_q <= k_left;
				cur_e_q <= mid;
			end else begin
				cur_k_q <= k_right;
				cur_b_q <= mid_p1;
			end
		end else if (cmd.up_rd) begin
			cur_k_q <= {1'b0, cur_k_q[AW-1:1]};
		end else if (cmd.q_visit) begin
			if (q_partial) begin
				// right half waits on the stack, walk continues left
				stk_k_q[sp_q[STK_IW-1:0]] <= k_right;
				stk_b_q[sp_q[STK_IW-1:0]] <= mid_p1;
				stk_e_q[sp_q[STK_IW-1:0]] <= cur_e_q;
				cur_k_q <= k_left;
				cur_e_q <= mid;
			end else if (!stk_empty) begin
				cur_k_q <= stk_k_q[sp_dec[STK_IW-1:0]];
				cur_b_q <= stk_b_q[sp_dec[STK_IW-1:0]];
				cur_e_q <= stk_e_q[sp_dec[STK_IW-1:0]];
			end
		end
		if (cmd.out_load) begin
			range_sum_q <= acc_next;
		end
	end

	always_comb begin
		status = '0;
		status.clr_last = (clr_addr_q == '1);
		status.is_query = in_is_query;
		status.in_skip = in_skip;
		status.is_leaf = (cur_b_q == cur_e_q);
		status.is_root = (cur_k_q == AW'(1));
		status.q_partial = q_partial;
		status.stk_empty = stk_empty;
		status.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;

	`RSST_ASSERT(a_stk_room, clk, arst_n, (cmd.q_visit && q_partial) |-> (sp_q < SP_W'(STK_D)), "query stack overflow")
	`RSST_ASSERT(a_out_slot, clk, arst_n, cmd.out_load |-> (!out_valid_q || !out_stall), "result overwritten before taken")
	`RSST_ASSERT(a_leaf_only, clk, arst_n, cmd.leaf_wr |-> (cur_b_q == cur_e_q), "element write off a leaf")
	`RSST_ASSERT(a_up_pair, clk, arst_n, cmd.up_wr |-> ($past(cmd.up_rd) && (cur_k_q != '0)), "parent refresh without child read")
	`RSST_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !out_valid_q, "result valid during reset")

endmodule

`default_nettype wire

/* rtl/range_sum_segment_tree_core.sv */
// Range sum segment tree over up to MAX_ELEMENTS signed 32-bit elements.
// Input requests (in_valid/in_stall): opcode set writes value at low_index
// and refreshes the partial sums above it, giving no result; opcode query
// returns one range_sum over low_index..high_index on out_valid/out_stall.
// cfg_we/cfg_wdata sets the element count, which the user must change only while the
// block is idle; the block itself does not enforce this. After reset a clearing pass
// zeroes the whole node memory; in_stall stays high until it ends.
// Set: the request is accepted, the walk descends to the leaf, writes it, then
// refreshes the partial sums level by level back up to the root. Each tree
// level needs a read of the child pair and a write of the parent.
// Query: the walk visits the tree one node at a time (at most about four nodes
// per level), then loads the sum into the output register; a query that is
// empty or out of range returns 0 without a walk. One request is in work at
// a time.
// The result sits in an output register; a stalled receiver holds it while
// the next request is already accepted and worked on, and a finished query
// waits only for that register to free up.
`default_nettype none

module range_sum_segment_tree_core
	import rsst_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [IDX_W-1:0]         low_index,
	input  logic [IDX_W-1:0]         high_index,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] range_sum
);

	localparam int POS_W = pos_width(MAX_ELEMENTS);

	logic [POS_W-1:0] last_q;
	logic [31:0]      cfg_n32;
	rsst_cmd_t        cmd;
	rsst_status_t     status;

	assign cfg_n32 = 32'(cfg_wdata);

	// last usable index, count clamped to 1..MAX_ELEMENTS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= POS_W'(MAX_ELEMENTS - 1);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				last_q <= '0;
			end else if (cfg_n32 > 32'(MAX_ELEMENTS)) begin
				last_q <= POS_W'(MAX_ELEMENTS - 1);
			end else begin
				last_q <= POS_W'(cfg_wdata - CNT_W'(1));
			end
		end
	end

	rsst_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	rsst_datapath #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.last(last_q),
		.opcode(opcode),
		.low_index(low_index),
		.high_index(high_index),
		.value(value),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.range_sum(range_sum)
	);

endmodule

`default_nettype wire

/* tb/sv/range_sum_segment_tree_checker.sv */
// checker for range_sum_segment_tree_core: keeps its own segment tree of node sums,
// predicts each query's range_sum, and compares every accepted result in order
// depends on rsst_pkg for widths, opcodes and the default element limit
`timescale 1ns / 100ps

module range_sum_segment_tree_checker
	import rsst_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     opcode,
	input  logic [IDX_W-1:0]         low_index,
	input  logic [IDX_W-1:0]         high_index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DATA_W-1:0] range_sum,
	output int                       fail_count,
	output int                       pending_count
);

	localparam int NODES = 4 * MAX_ELEMENTS_DEF;

	logic [DATA_W-1:0] node_sums [NODES];
	logic [CNT_W-1:0]  element_count;
	logic [DATA_W-1:0] expected_sums [$];

	function automatic int unsigned used_count();
		if (element_count == 0) return 1;
		if (element_count > MAX_ELEMENTS_DEF) return MAX_ELEMENTS_DEF;
		return 32'(element_count);
	endfunction

	function automatic logic [DATA_W-1:0] node_at(int unsigned k);
		return (k < NODES) ? node_sums[k] : '0;
	endfunction

	function automatic void set_element(int unsigned pos, logic [DATA_W-1:0] v);
		int unsigned path [32];
		int unsigned depth, k, b, e, m;
		k = 1;
		b = 0;
		e = used_count() - 1;
		depth = 0;
		while (b != e) begin
			path[depth] = k;
			depth++;
			m = (b + e) / 2;
			if (pos <= m) begin
				k = 2 * k;
				e = m;
			end else begin
				k = 2 * k + 1;
				b = m + 1;
			end
		end
		if (k < NODES) node_sums[k] = v;
		while (depth > 0) begin
			depth--;
			node_sums[path[depth]] = node_at(2 * path[depth]) + node_at(2 * path[depth] + 1);
		end
	endfunction

	function automatic logic [DATA_W-1:0] sum_span(int unsigned lo, int unsigned hi);
		int unsigned ks [64];
		int unsigned bs [64];
		int unsigned es [64];
		int unsigned sp, k, b, e, m;
		logic [DATA_W-1:0] acc;
		acc = '0;
		ks[0] = 1;
		bs[0] = 0;
		es[0] = used_count() - 1;
		sp = 1;
		while (sp > 0) begin
			sp--;
			k = ks[sp];
			b = bs[sp];
			e = es[sp];
			if (lo > e || hi < b) begin
			end else if (b >= lo && e <= hi) begin
				acc += node_at(k);
			end else begin
				m = (b + e) / 2;
				ks[sp] = 2 * k;
				bs[sp] = b;
				es[sp] = m;
				ks[sp + 1] = 2 * k + 1;
				bs[sp + 1] = m + 1;
				es[sp + 1] = e;
				sp += 2;
			end
		end
		return acc;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("%0t mismatch: %s got %0d expected %0d", $time, what, $signed(got),
			$signed(want));
		fail_count++;
	endtask

	always @(posedge clk) begin : watch
		int unsigned n, lo, hi;
		logic [DATA_W-1:0] want;
		if (!arst_n) begin
			foreach (node_sums[i]) node_sums[i] = '0;
			element_count = CNT_W'(MAX_ELEMENTS_DEF);
			expected_sums.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) element_count = cfg_wdata;
			if (in_valid && !in_stall) begin
				n = used_count();
				lo = 32'(low_index);
				hi = 32'(high_index);
				if (rsst_op_t'(opcode) == OP_SET) begin
					if (lo < n) set_element(lo, value);
				end else if (lo > hi || lo >= n) begin
					expected_sums.push_back('0);
				end else begin
					if (hi > n - 1) hi = n - 1;
					expected_sums.push_back(sum_span(lo, hi));
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_sums.size() == 0) begin
					report_mismatch("range_sum with no query waiting", range_sum, '0);
				end else begin
					want = expected_sums.pop_front();
					if (range_sum !== want) report_mismatch("range_sum", range_sum, want);
				end
			end
		end
		pending_count <= expected_sums.size();
	end

endmodule

/* tb/sv/range_sum_segment_tree_core_tb.sv */
// testbench top for range_sum_segment_tree_core: drives set and query requests,
// element count writes and receiver stalls; the verdict comes from the checker and a watchdog
// depends on rsst_pkg, range_sum_segment_tree_core and range_sum_segment_tree_checker
`timescale 1ns / 100ps

module range_sum_segment_tree_core_tb;
	import rsst_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES = 300;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we = 1'b0;
	logic [CNT_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     opcode = 1'b0;
	logic [IDX_W-1:0]         low_index = '0;
	logic [IDX_W-1:0]         high_index = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] range_sum;

	int          fail_count;
	int          pending_count;
	int          idle_cycles = 0;
	int unsigned active_n = MAX_ELEMENTS_DEF;
	bit          no_idle = 1'b0;
	bit          hold_req = 1'b0;

	always #6 clk = ~clk;

	range_sum_segment_tree_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.low_index  (low_index),
		.high_index (high_index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.range_sum  (range_sum)
	);

	range_sum_segment_tree_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.low_index     (low_index),
		.high_index    (high_index),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.range_sum     (range_sum),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// no progress on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= !no_idle && ($urandom_range(0, 99) < 35);
		end
	end

	task automatic send_request(rsst_op_t op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
		logic [DATA_W-1:0] val);
		while (!no_idle && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		low_index <= lo;
		high_index <= hi;
		value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic set_count(logic [CNT_W-1:0] cnt);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_n = (cnt == 0) ? 1 : ((cnt > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : 32'(cnt));
	endtask

	task automatic run_random(int items);
		rsst_op_t op;
		logic [IDX_W-1:0] lo, hi;
		logic [DATA_W-1:0] val;
		int pick;
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(0, 99);
			op = ($urandom_range(0, 99) < 45) ? OP_SET : OP_QUERY;
			lo = IDX_W'($urandom);
			hi = IDX_W'($urandom);
			val = $urandom;
			if (pick < 15) val = $urandom_range(0, 15) - 8;
			else if (pick < 25) val = pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
			pick = $urandom_range(0, 99);
			if (op == OP_SET) begin
				if (pick < 85) lo = IDX_W'($urandom_range(0, active_n - 1));
			end else if (pick < 80) begin
				lo = IDX_W'($urandom_range(0, active_n - 1));
				hi = IDX_W'($urandom_range(lo, active_n - 1));
			end else if (pick < 90) begin
				lo = IDX_W'($urandom_range(0, active_n - 1));
				hi = IDX_W'($urandom_range(lo, 1023));
			end
			send_request(op, lo, hi, val);
		end
	endtask

	initial begin
		int unsigned phase_counts [8];
		int phase_items [8];
		arst_n <= 1'b0;
		phase_counts = '{1, 2, 37, 1000, 0, 0, 2047, 700};
		phase_items = '{60, 80, 150, 180, 150, 40, 150, 180};
		phase_counts[4] = $urandom_range(3, 1023);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// extremes, wrap-around and an empty range at the reset count
		send_request(OP_SET, 0, 0, 32'h7FFF_FFFF);
		send_request(OP_SET, 1, 1023, 32'h0000_0001);
		send_request(OP_SET, 1023, 0, 32'h8000_0000);
		send_request(OP_SET, 512, 1023, 32'hFFFF_FFFF);
		send_request(OP_SET, 341, 682, 32'h5555_5555);
		send_request(OP_SET, 682, 341, 32'hAAAA_AAAA);
		send_request(OP_QUERY, 0, 1, 32'hFFFF_FFFF);
		send_request(OP_QUERY, 0, 1023, 0);
		send_request(OP_QUERY, 1023, 1023, 0);
		send_request(OP_QUERY, 600, 3, 0);
		send_request(OP_QUERY, 0, 0, 0);
		send_request(OP_QUERY, 341, 682, 0);
		send_request(OP_SET, 1023, 0, 0);

		// small count over the loaded tree, sets and ranges beyond it
		set_count(5);
		send_request(OP_QUERY, 3, 1023, 0);
		send_request(OP_SET, 7, 0, 99);
		send_request(OP_QUERY, 7, 9, 0);
		send_request(OP_SET, 4, 0, -5);
		send_request(OP_QUERY, 0, 4, 0);

		// zero count acts as one element
		set_count(0);
		send_request(OP_SET, 0, 0, 12);
		send_request(OP_SET, 1, 0, 3);
		send_request(OP_QUERY, 0, 1023, 0);

		// count above the limit acts as the limit
		set_count(2047);
		send_request(OP_QUERY, 0, 1023, 0);
		send_request(OP_QUERY, 200, 900, 0);

		// back-to-back stretch with a long receiver hold-off
		set_count(1024);
		no_idle = 1'b1;
		hold_req = 1'b1;
		run_random(200);
		no_idle = 1'b0;

		for (int p = 0; p < 8; p++) begin
			set_count(CNT_W'(phase_counts[p]));
			run_random(phase_items[p]);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
